>>> rtl/btbfa_pkg.sv
// ----------------------------------------------------------------------------
// btbfa_pkg
// Shared types and constants of the boundary-tag best-fit allocator.
// ----------------------------------------------------------------------------
package btbfa_pkg;

   // pool depth in bytes, a power of two from 64 up
   localparam int POOL_BYTES_DEF = 4096;
   // pool size in use right after reset
   localparam int PSIZE_RESET    = 4096;
   localparam int PSIZE_MIN      = 64;
   localparam int CSR_W          = 13;
   localparam int SIZE_W         = 12;
   localparam int ADDR_W         = 12;
   localparam int TAG_W          = 32;
   // signed width of offset and tag arithmetic; covers sums of two tag magnitudes
   localparam int WW             = 40;

   typedef logic signed [WW-1:0] wide_type;

   // one access of the tag port: read or write of a 4-byte tag at a byte offset
   typedef struct packed {
      logic             wr;
      wide_type         at;
      logic [TAG_W-1:0] wdata;
   } tag_cmd_type;

endpackage

>>> rtl/btbfa_ram.sv
// ----------------------------------------------------------------------------
// btbfa_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module btbfa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

>>> rtl/btbfa_tag_port.sv
// ----------------------------------------------------------------------------
// btbfa_tag_port
// Reads or writes one unaligned little-endian 4-byte tag per cycle over four
// byte banks. Tags outside the pool read as zero and drop writes.
// ----------------------------------------------------------------------------
module btbfa_tag_port #(
   parameter int POOL_BYTES = btbfa_pkg::POOL_BYTES_DEF
) (
   input  logic                                  clock,
   input  btbfa_pkg::tag_cmd_type                cmd,
   input  logic [$clog2(POOL_BYTES+1)-1:0]       psize,
   output logic signed [btbfa_pkg::TAG_W-1:0]    rd_tag
);
   import btbfa_pkg::*;

   localparam int AW = $clog2(POOL_BYTES);
   localparam int RW = AW - 2;

   wide_type   psize_w;
   wide_type   end_at;
   logic       in_pool;
   logic       in_pool_ff;
   logic [1:0] lo_ff;
   logic [7:0] q [4];
   logic [7:0] b [4];

   assign psize_w = signed'(WW'(psize));
   assign end_at  = cmd.at + wide_type'(4);
   assign in_pool = (cmd.at >= 0) && (end_at <= psize_w);

   for (genvar k = 0; k < 4; k++) begin : g_bank
      logic [1:0]    off;
      logic [AW:0]   sum;
      logic [TAG_W-1:0] sh;

      assign off = 2'(k) - cmd.at[1:0];
      assign sum = {1'b0, cmd.at[AW-1:0]} + (AW+1)'(off);
      assign sh  = cmd.wdata >> {off, 3'b000};

      btbfa_ram #(
         .WIDTH(8),
         .DEPTH(POOL_BYTES/4)
      ) u_ram (
         .clock(clock),
         .we   (cmd.wr & in_pool),
         .addr (sum[RW+1:2]),
         .wdata(sh[7:0]),
         .rdata(q[k])
      );

      // byte k of the tag sits in bank lo+k
      assign b[k] = q[2'(lo_ff + 2'(k))];
   end

   always_ff @(posedge clock) begin
      in_pool_ff <= in_pool;
      lo_ff      <= cmd.at[1:0];
   end

   assign rd_tag = in_pool_ff ? signed'({b[3], b[2], b[1], b[0]}) : '0;

endmodule

>>> rtl/boundary_tag_best_fit_allocator_unit.sv
// ----------------------------------------------------------------------------
// boundary_tag_best_fit_allocator_unit
// Best-fit byte-pool allocator with signed header and footer tags per block.
// ----------------------------------------------------------------------------
// One request at a time. All pool accesses go through one tag port that reads
// or writes one 4-byte tag per cycle, so that port sets the timing: an
// allocate reads each block header in turn and on a fit writes four tags, a
// free rewrites the block's tags and merges free neighbours, and the result
// then waits in an output register. After reset and after every pool_size
// write, the tags of the initial free block go down before a request is taken.
module boundary_tag_best_fit_allocator_unit #(
   parameter int POOL_BYTES = btbfa_pkg::POOL_BYTES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [23:0]                   req_tdata,  // request_size, free_address
   input  logic                          req_tuser,  // func
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [15:0]                   rsp_tdata,  // ok, address, zero fill
   input  logic                          csr_we,
   input  logic [btbfa_pkg::CSR_W-1:0]   csr_wdata
);
   import btbfa_pkg::*;

   localparam int PW = $clog2(POOL_BYTES+1);

   typedef enum logic [19:0] {
      ST_IDLE  = 20'h00001,
      ST_INIT0 = 20'h00002,
      ST_INIT1 = 20'h00004,
      ST_A_RD  = 20'h00008,
      ST_A_EV  = 20'h00010,
      ST_A_FIN = 20'h00020,
      ST_A_W0  = 20'h00040,
      ST_A_W1  = 20'h00080,
      ST_A_W2  = 20'h00100,
      ST_A_W3  = 20'h00200,
      ST_F_RD0 = 20'h00400,
      ST_F_S   = 20'h00800,
      ST_F_W1  = 20'h01000,
      ST_F_RD1 = 20'h02000,
      ST_F_N1  = 20'h04000,
      ST_F_W2  = 20'h08000,
      ST_F_RD2 = 20'h10000,
      ST_F_N2  = 20'h20000,
      ST_F_W3  = 20'h40000,
      ST_DONE  = 20'h80000
   } state_type;

   localparam wide_type C4  = wide_type'(4);
   localparam wide_type C8  = wide_type'(8);
   localparam wide_type C12 = wide_type'(12);

   state_type          state_ff, state_in;
   logic [PW-1:0]      psize_ff, psize_in;
   wide_type           p_ff, p_in;
   wide_type           best_ff, best_in;
   wide_type           head_ff, head_in;
   wide_type           a_ff, a_in;
   wide_type           s_ff, s_in;
   wide_type           n_ff, n_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic               res_ok_ff, res_ok_in;
   logic [ADDR_W-1:0]  res_addr_ff, res_addr_in;
   logic               rsp_tvalid_ff, rsp_tvalid_in;
   logic [15:0]        rsp_tdata_ff, rsp_tdata_in;

   tag_cmd_type              cmd;
   logic signed [TAG_W-1:0]  rd_tag;
   wide_type                 t, t_mag, psw, sz, sum_s, pay;
   logic                     out_free;
   int                       clamp;

   btbfa_tag_port #(
      .POOL_BYTES(POOL_BYTES)
   ) u_tag (
      .clock (clock),
      .cmd   (cmd),
      .psize (psize_ff),
      .rd_tag(rd_tag)
   );

   assign t        = wide_type'(rd_tag);
   assign t_mag    = (t < 0) ? -t : t;
   assign psw      = signed'(WW'(psize_ff));
   assign sz       = signed'(WW'(size_ff));
   assign sum_s    = s_ff + t + C8;
   assign pay      = head_ff + C4;
   assign out_free = !rsp_tvalid_ff || rsp_tready;

   always_comb begin
      clamp = int'(csr_wdata);
      if (clamp < PSIZE_MIN) begin
         clamp = PSIZE_MIN;
      end
      if (clamp > POOL_BYTES) begin
         clamp = POOL_BYTES;
      end
   end

   always_comb begin
      state_in      = state_ff;
      psize_in      = psize_ff;
      p_in          = p_ff;
      best_in       = best_ff;
      head_in       = head_ff;
      a_in          = a_ff;
      s_in          = s_ff;
      n_in          = n_ff;
      size_in       = size_ff;
      res_ok_in     = res_ok_ff;
      res_addr_in   = res_addr_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      req_tready    = 1'b0;
      cmd.wr        = 1'b0;
      cmd.at        = p_ff;
      cmd.wdata     = '0;

      case (state_ff)
         ST_INIT0: begin
            cmd.wr    = 1'b1;
            cmd.at    = '0;
            cmd.wdata = TAG_W'(psw - C8);
            state_in  = ST_INIT1;
         end
         ST_INIT1: begin
            cmd.wr    = 1'b1;
            cmd.at    = psw - C4;
            cmd.wdata = TAG_W'(psw - C8);
            state_in  = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               size_in  = req_tdata[11:0];
               a_in     = signed'(WW'(req_tdata[23:12]));
               p_in     = '0;
               best_in  = psw;
               head_in  = '0;
               state_in = req_tuser ? ST_F_RD0 : ST_A_RD;
            end
         end
         ST_A_RD: begin
            cmd.at   = p_ff;
            state_in = (p_ff + C4 > psw) ? ST_A_FIN : ST_A_EV;
         end
         ST_A_EV: begin
            if (t >= sz + C8 && t < best_ff) begin
               best_in = t;
               head_in = p_ff;
            end
            p_in     = p_ff + C8 + t_mag;
            state_in = ST_A_RD;
         end
         ST_A_FIN: begin
            if (best_ff < psw) begin
               state_in = ST_A_W0;
            end else begin
               res_ok_in   = 1'b0;
               res_addr_in = '0;
               state_in    = ST_DONE;
            end
         end
         ST_A_W0: begin
            cmd.wr    = 1'b1;
            cmd.at    = head_ff;
            cmd.wdata = TAG_W'(-sz);
            state_in  = ST_A_W1;
         end
         ST_A_W1: begin
            cmd.wr    = 1'b1;
            cmd.at    = head_ff + C4 + sz;
            cmd.wdata = TAG_W'(-sz);
            state_in  = ST_A_W2;
         end
         ST_A_W2: begin
            cmd.wr    = 1'b1;
            cmd.at    = head_ff + sz + C8;
            cmd.wdata = TAG_W'(best_ff - sz - C8);
            state_in  = ST_A_W3;
         end
         ST_A_W3: begin
            cmd.wr      = 1'b1;
            cmd.at      = head_ff + C4 + best_ff;
            cmd.wdata   = TAG_W'(best_ff - sz - C8);
            res_ok_in   = 1'b1;
            res_addr_in = pay[ADDR_W-1:0];
            state_in    = ST_DONE;
         end
         ST_F_RD0: begin
            cmd.at   = a_ff - C4;
            state_in = ST_F_S;
         end
         ST_F_S: begin
            s_in      = t_mag;
            cmd.wr    = 1'b1;
            cmd.at    = a_ff - C4;
            cmd.wdata = TAG_W'(t_mag);
            state_in  = ST_F_W1;
         end
         ST_F_W1: begin
            cmd.wr    = 1'b1;
            cmd.at    = a_ff + s_ff;
            cmd.wdata = TAG_W'(s_ff);
            state_in  = ST_F_RD1;
         end
         ST_F_RD1: begin
            cmd.at   = a_ff + s_ff + C4;
            state_in = ST_F_N1;
         end
         ST_F_N1: begin
            // merge with a free following block
            if (t > 0) begin
               s_in      = sum_s;
               cmd.wr    = 1'b1;
               cmd.at    = a_ff - C4;
               cmd.wdata = TAG_W'(sum_s);
               state_in  = ST_F_W2;
            end else begin
               state_in = ST_F_RD2;
            end
         end
         ST_F_W2: begin
            cmd.wr    = 1'b1;
            cmd.at    = a_ff + s_ff;
            cmd.wdata = TAG_W'(s_ff);
            state_in  = ST_F_RD2;
         end
         ST_F_RD2: begin
            cmd.at   = a_ff - C8;
            state_in = ST_F_N2;
         end
         ST_F_N2: begin
            res_ok_in   = 1'b1;
            res_addr_in = '0;
            // merge into a free preceding block
            if (t > 0) begin
               n_in      = t;
               cmd.wr    = 1'b1;
               cmd.at    = a_ff - C12 - t;
               cmd.wdata = TAG_W'(sum_s);
               state_in  = ST_F_W3;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_F_W3: begin
            cmd.wr    = 1'b1;
            cmd.at    = a_ff + s_ff;
            cmd.wdata = TAG_W'(s_ff + n_ff + C8);
            state_in  = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_tdata_in  = {3'b000, res_addr_ff, res_ok_ff};
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_INIT0;
         end
      endcase

      if (csr_we) begin
         psize_in = PW'(clamp);
         state_in = ST_INIT0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_INIT0;
         psize_ff      <= PW'((PSIZE_RESET > POOL_BYTES) ? POOL_BYTES : PSIZE_RESET);
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         psize_ff      <= psize_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      p_ff         <= p_in;
      best_ff      <= best_in;
      head_ff      <= head_in;
      a_ff         <= a_in;
      s_ff         <= s_in;
      n_ff         <= n_in;
      size_ff      <= size_in;
      res_ok_ff    <= res_ok_in;
      res_addr_ff  <= res_addr_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   a_csr_relays: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> state_ff == ST_INIT0)
      else $error("pool not re-laid after pool_size write");

   a_req_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && !csr_we) |=> state_ff != ST_IDLE)
      else $error("accepted request did not start work");

   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_A_EV || state_ff == ST_A_FIN) |-> best_ff <= psw)
      else $error("best fit exceeds pool size");

   a_fail_addr: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[0] || rsp_tdata[12:1] == '0))
      else $error("failed allocate returned an address");

endmodule
